// File: rtl/csp_pkg.sv
// Shared types and constants for the channel span packer.
`timescale 1ns / 1ps
package csp_pkg;

    // Fixed field widths of the stream payloads
    localparam int DEV_IN_W  = 8;
    localparam int ADDR_W    = 64;
    localparam int SIZE_W    = 32;
    localparam int OUT_W     = 41;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 88;

    // Shared unit operation codes
    localparam logic [1:0] ALU_ADD = 2'd0;
    localparam logic [1:0] ALU_SUB = 2'd1;
    localparam logic [1:0] ALU_LT  = 2'd2;
    localparam logic [1:0] ALU_EQ  = 2'd3;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_alu_flags;

endpackage

// File: rtl/csp_alu.sv
// Shared add / subtract / compare unit built around one adder.
`timescale 1ns / 1ps
module csp_alu #(
    parameter int W = 56
) (
    input  logic [1:0]          i_op,
    input  logic [W-1:0]        i_a,
    input  logic [W-1:0]        i_b,
    output logic [W-1:0]        o_res,
    output csp_pkg::t_alu_flags o_flags
);

    logic         w_inv;
    logic [W-1:0] w_b;
    logic [W:0]   w_sum;

    // subtract and less-than share the adder: a + ~b + 1
    assign w_inv = (i_op == csp_pkg::ALU_SUB) || (i_op == csp_pkg::ALU_LT);
    assign w_b   = w_inv ? ~i_b : i_b;
    assign w_sum = {1'b0, i_a} + {1'b0, w_b} + {{W{1'b0}}, w_inv};

    assign o_res      = w_sum[W-1:0];
    assign o_flags.lt = ~w_sum[W];
    assign o_flags.eq = (i_a == i_b);

endmodule

// File: rtl/csp_table.sv
// Region table: span memory, segment base memory and per-entry valid bits.
`timescale 1ns / 1ps
module csp_table #(
    parameter int N      = 16,
    parameter int IDX_W  = 4,
    parameter int KEY_W  = 36,
    parameter int LOW_W  = 36,
    parameter int HIGH_W = 37,
    parameter int BASE_W = 41
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clr_valid,
    input  logic              i_set_valid,
    input  logic              i_ent_we,
    input  logic [IDX_W-1:0]  i_ent_idx,
    input  logic [KEY_W-1:0]  i_ent_key,
    input  logic [LOW_W-1:0]  i_ent_low,
    input  logic [HIGH_W-1:0] i_ent_high,
    input  logic              i_base_we,
    input  logic [IDX_W-1:0]  i_base_idx,
    input  logic [BASE_W-1:0] i_base_data,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_idx,
    output logic [KEY_W-1:0]  o_rd_key,
    output logic [LOW_W-1:0]  o_rd_low,
    output logic [HIGH_W-1:0] o_rd_high,
    output logic [BASE_W-1:0] o_rd_base,
    output logic [N-1:0]      o_valid
);

    logic [KEY_W-1:0]  r_key  [N];
    logic [LOW_W-1:0]  r_low  [N];
    logic [HIGH_W-1:0] r_high [N];
    logic [BASE_W-1:0] r_base [N];
    logic [N-1:0]      r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clr_valid) begin
            r_valid <= '0;
        end else if (i_set_valid) begin
            r_valid[i_ent_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_key[i_ent_idx]  <= i_ent_key;
            r_low[i_ent_idx]  <= i_ent_low;
            r_high[i_ent_idx] <= i_ent_high;
        end
        if (i_rd_en) begin
            o_rd_key  <= r_key[i_rd_idx];
            o_rd_low  <= r_low[i_rd_idx];
            o_rd_high <= r_high[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_base_we) begin
            r_base[i_base_idx] <= i_base_data;
        end
        if (i_rd_en) begin
            o_rd_base <= r_base[i_rd_idx];
        end
    end

    assign o_valid = r_valid;

endmodule

// File: rtl/channel_span_pack_and_translate.sv
// Top level: span table sequencer for chunk collection, packing and translation.
`timescale 1ns / 1ps
// Takes one item at a time and drops o_s_tready until it is done. All work runs
// through one adder/comparator and a table with a single registered read port.
// After acceptance a chunk keeps the input busy through end address, key search,
// then min/max update and write-back; a zero-size chunk without tlast is taken in
// its acceptance cycle alone. Packing, started by a chunk with tlast, walks every
// valid entry against every other. A result sits in an output register, so the
// next item is taken while it waits; a later result holds in its last cycle until
// that register frees. Valid bits live in flops, so reset needs no clearing pass.
module channel_span_pack_and_translate #(
    parameter int MAX_REGIONS = 16,
    parameter int LOCAL_BITS  = 36,
    parameter int DEVICE_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // device[7:0], bus_address[71:8], chunk_size[103:72]
    input  logic [csp_pkg::S_TDATA_W-1:0] i_s_tdata,
    // kind
    input  logic                          i_s_tuser,
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // found[0], packed_offset[41:1], total_size[82:42], table_overflow[83], zero pad
    output logic [csp_pkg::M_TDATA_W-1:0] o_m_tdata,
    // is_pack_result
    output logic                          o_m_tuser
);

    localparam int DEV_W  = (DEVICE_BITS < csp_pkg::DEV_IN_W) ? DEVICE_BITS : csp_pkg::DEV_IN_W;
    localparam int CH_W   = csp_pkg::ADDR_W - LOCAL_BITS;
    localparam int KEY_W  = DEV_W + CH_W;
    localparam int HIGH_W = ((LOCAL_BITS > csp_pkg::SIZE_W) ? LOCAL_BITS : csp_pkg::SIZE_W) + 1;
    localparam int OUT_W  = csp_pkg::OUT_W;
    localparam int W1     = (KEY_W > HIGH_W) ? KEY_W : HIGH_W;
    localparam int ALU_W  = (W1 > OUT_W) ? W1 : OUT_W;
    localparam int IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int PAD_W  = csp_pkg::M_TDATA_W - (3 + 2 * OUT_W);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_END      = 5'd1;
    localparam logic [4:0] S_FIND     = 5'd2;
    localparam logic [4:0] S_FIND_CMP = 5'd3;
    localparam logic [4:0] S_MIN      = 5'd4;
    localparam logic [4:0] S_MAX      = 5'd5;
    localparam logic [4:0] S_WRITE    = 5'd6;
    localparam logic [4:0] S_P_OUTER  = 5'd7;
    localparam logic [4:0] S_P_LOADI  = 5'd8;
    localparam logic [4:0] S_P_TOT    = 5'd9;
    localparam logic [4:0] S_P_INNER  = 5'd10;
    localparam logic [4:0] S_P_LT     = 5'd11;
    localparam logic [4:0] S_P_SUBJ   = 5'd12;
    localparam logic [4:0] S_P_ACC    = 5'd13;
    localparam logic [4:0] S_L_FIND   = 5'd14;
    localparam logic [4:0] S_L_CMP    = 5'd15;
    localparam logic [4:0] S_L_GE     = 5'd16;
    localparam logic [4:0] S_L_OFF    = 5'd17;
    localparam logic [4:0] S_L_SPAN   = 5'd18;
    localparam logic [4:0] S_L_IN     = 5'd19;
    localparam logic [4:0] S_L_ADD    = 5'd20;
    localparam logic [4:0] S_OUT      = 5'd21;

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_REGIONS);

    // Input fields
    logic [csp_pkg::DEV_IN_W-1:0] w_device;
    logic [csp_pkg::ADDR_W-1:0]   w_addr;
    logic [csp_pkg::SIZE_W-1:0]   w_size;
    logic                         w_s_fire;

    // Sequencer and datapath registers
    logic [4:0]            r_state;
    logic [KEY_W-1:0]      r_key;
    logic [LOCAL_BITS-1:0] r_local;
    logic [csp_pkg::SIZE_W-1:0] r_size;
    logic                  r_last;
    logic [HIGH_W-1:0]     r_end;
    logic [LOCAL_BITS-1:0] r_low;
    logic [HIGH_W-1:0]     r_high;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      r_jdx;
    logic                  r_free_ok;
    logic [IDX_W-1:0]      r_free;
    logic [IDX_W-1:0]      r_hit;
    logic [KEY_W-1:0]      r_ikey;
    logic [HIGH_W-1:0]     r_span;
    logic [HIGH_W-1:0]     r_off;
    logic [OUT_W-1:0]      r_acc;
    logic [OUT_W-1:0]      r_total;
    logic                  r_packed;
    logic                  r_overflow;
    logic                  r_res_found;
    logic [OUT_W-1:0]      r_res_off;
    logic                  r_res_pack;

    // Output register
    logic                  r_out_valid;
    logic                  r_out_found;
    logic [OUT_W-1:0]      r_out_off;
    logic [OUT_W-1:0]      r_out_total;
    logic                  r_out_ovf;
    logic                  r_out_pack;
    logic                  w_out_load;

    // Table and unit connections
    logic                  w_clr_valid;
    logic                  w_set_valid;
    logic                  w_ent_we;
    logic [IDX_W-1:0]      w_ent_idx;
    logic [LOCAL_BITS-1:0] w_ent_low;
    logic [HIGH_W-1:0]     w_ent_high;
    logic                  w_base_we;
    logic                  w_rd_en;
    logic [IDX_W-1:0]      w_rd_idx;
    logic [KEY_W-1:0]      w_rd_key;
    logic [LOCAL_BITS-1:0] w_rd_low;
    logic [HIGH_W-1:0]     w_rd_high;
    logic [OUT_W-1:0]      w_rd_base;
    logic [MAX_REGIONS-1:0] w_valid;
    logic [1:0]            w_alu_op;
    logic [ALU_W-1:0]      w_alu_a;
    logic [ALU_W-1:0]      w_alu_b;
    logic [ALU_W-1:0]      w_alu_res;
    csp_pkg::t_alu_flags   w_flags;
    logic                  w_idx_end;
    logic                  w_jdx_end;
    logic                  w_idx_valid;
    logic                  w_jdx_valid;

    assign w_device = i_s_tdata[csp_pkg::DEV_IN_W-1:0];
    assign w_addr   = i_s_tdata[csp_pkg::DEV_IN_W +: csp_pkg::ADDR_W];
    assign w_size   = i_s_tdata[csp_pkg::DEV_IN_W + csp_pkg::ADDR_W +: csp_pkg::SIZE_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_fire   = i_s_tvalid && o_s_tready;

    assign w_idx_end   = (r_idx == CNT_END);
    assign w_jdx_end   = (r_jdx == CNT_END);
    assign w_idx_valid = !w_idx_end && w_valid[r_idx[IDX_W-1:0]];
    assign w_jdx_valid = !w_jdx_end && w_valid[r_jdx[IDX_W-1:0]];

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    csp_table #(
        .N      (MAX_REGIONS),
        .IDX_W  (IDX_W),
        .KEY_W  (KEY_W),
        .LOW_W  (LOCAL_BITS),
        .HIGH_W (HIGH_W),
        .BASE_W (OUT_W)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr_valid (w_clr_valid),
        .i_set_valid (w_set_valid),
        .i_ent_we    (w_ent_we),
        .i_ent_idx   (w_ent_idx),
        .i_ent_key   (r_key),
        .i_ent_low   (w_ent_low),
        .i_ent_high  (w_ent_high),
        .i_base_we   (w_base_we),
        .i_base_idx  (r_idx[IDX_W-1:0]),
        .i_base_data (r_acc),
        .i_rd_en     (w_rd_en),
        .i_rd_idx    (w_rd_idx),
        .o_rd_key    (w_rd_key),
        .o_rd_low    (w_rd_low),
        .o_rd_high   (w_rd_high),
        .o_rd_base   (w_rd_base),
        .o_valid     (w_valid)
    );

    csp_alu #(
        .W (ALU_W)
    ) u_alu (
        .i_op    (w_alu_op),
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .o_res   (w_alu_res),
        .o_flags (w_flags)
    );

    // Table port and shared unit steering
    always_comb begin
        w_clr_valid = 1'b0;
        w_set_valid = 1'b0;
        w_ent_we    = 1'b0;
        w_ent_idx   = r_free;
        w_ent_low   = r_local;
        w_ent_high  = r_end;
        w_base_we   = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_idx    = r_idx[IDX_W-1:0];
        w_alu_op    = csp_pkg::ALU_ADD;
        w_alu_a     = '0;
        w_alu_b     = '0;
        case (r_state)
            S_IDLE: begin
                w_clr_valid = w_s_fire && !i_s_tuser && r_packed;
            end
            S_END: begin
                w_alu_a = ALU_W'(r_local);
                w_alu_b = ALU_W'(r_size);
            end
            S_FIND: begin
                w_rd_en = w_idx_valid;
                if (w_idx_end && r_free_ok) begin
                    w_ent_we    = 1'b1;
                    w_set_valid = 1'b1;
                end
            end
            S_FIND_CMP: begin
                w_alu_op = csp_pkg::ALU_EQ;
                w_alu_a  = ALU_W'(w_rd_key);
                w_alu_b  = ALU_W'(r_key);
            end
            S_MIN: begin
                w_alu_op = csp_pkg::ALU_LT;
                w_alu_a  = ALU_W'(r_local);
                w_alu_b  = ALU_W'(r_low);
            end
            S_MAX: begin
                w_alu_op = csp_pkg::ALU_LT;
                w_alu_a  = ALU_W'(r_high);
                w_alu_b  = ALU_W'(r_end);
            end
            S_WRITE: begin
                w_ent_we   = 1'b1;
                w_ent_idx  = r_hit;
                w_ent_low  = r_low;
                w_ent_high = r_high;
            end
            S_P_OUTER: begin
                w_rd_en = w_idx_valid;
            end
            S_P_LOADI: begin
                w_alu_op = csp_pkg::ALU_SUB;
                w_alu_a  = ALU_W'(w_rd_high);
                w_alu_b  = ALU_W'(w_rd_low);
            end
            S_P_TOT: begin
                w_alu_a = ALU_W'(r_total);
                w_alu_b = ALU_W'(r_span);
            end
            S_P_INNER: begin
                w_rd_en   = w_jdx_valid;
                w_rd_idx  = r_jdx[IDX_W-1:0];
                w_base_we = w_jdx_end;
            end
            S_P_LT: begin
                w_alu_op = csp_pkg::ALU_LT;
                w_alu_a  = ALU_W'(w_rd_key);
                w_alu_b  = ALU_W'(r_ikey);
            end
            S_P_SUBJ: begin
                w_alu_op = csp_pkg::ALU_SUB;
                w_alu_a  = ALU_W'(w_rd_high);
                w_alu_b  = ALU_W'(w_rd_low);
            end
            S_P_ACC: begin
                w_alu_a = ALU_W'(r_acc);
                w_alu_b = ALU_W'(r_span);
            end
            S_L_FIND: begin
                w_rd_en = w_idx_valid;
            end
            S_L_CMP: begin
                w_alu_op = csp_pkg::ALU_EQ;
                w_alu_a  = ALU_W'(w_rd_key);
                w_alu_b  = ALU_W'(r_key);
            end
            S_L_GE: begin
                w_alu_op = csp_pkg::ALU_LT;
                w_alu_a  = ALU_W'(r_local);
                w_alu_b  = ALU_W'(w_rd_low);
            end
            S_L_OFF: begin
                w_alu_op = csp_pkg::ALU_SUB;
                w_alu_a  = ALU_W'(r_local);
                w_alu_b  = ALU_W'(w_rd_low);
            end
            S_L_SPAN: begin
                w_alu_op = csp_pkg::ALU_SUB;
                w_alu_a  = ALU_W'(w_rd_high);
                w_alu_b  = ALU_W'(w_rd_low);
            end
            S_L_IN: begin
                w_alu_op = csp_pkg::ALU_LT;
                w_alu_a  = ALU_W'(r_off);
                w_alu_b  = ALU_W'(r_span);
            end
            S_L_ADD: begin
                w_alu_a = ALU_W'(w_rd_base);
                w_alu_b = ALU_W'(r_off);
            end
            default: begin
                w_alu_op = csp_pkg::ALU_ADD;
            end
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_packed    <= 1'b0;
            r_overflow  <= 1'b0;
            r_total     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_s_fire) begin
                        r_key       <= {w_device[DEV_W-1:0], w_addr[csp_pkg::ADDR_W-1:LOCAL_BITS]};
                        r_local     <= w_addr[LOCAL_BITS-1:0];
                        r_size      <= w_size;
                        r_last      <= i_s_tlast;
                        r_idx       <= '0;
                        r_free_ok   <= 1'b0;
                        r_res_found <= 1'b0;
                        r_res_off   <= '0;
                        r_res_pack  <= 1'b0;
                        if (i_s_tuser) begin
                            r_state <= r_packed ? S_L_FIND : S_OUT;
                        end else begin
                            // total only reads back once packed, and is zeroed before packing
                            if (r_packed) begin
                                r_packed   <= 1'b0;
                                r_overflow <= 1'b0;
                            end
                            if (w_size != '0) begin
                                r_state <= S_END;
                            end else if (i_s_tlast) begin
                                r_total <= '0;
                                r_state <= S_P_OUTER;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                S_END: begin
                    r_end   <= w_alu_res[HIGH_W-1:0];
                    r_state <= S_FIND;
                end
                S_FIND: begin
                    if (w_idx_end) begin
                        if (!r_free_ok) begin
                            r_overflow <= 1'b1;
                        end
                        r_idx   <= '0;
                        r_total <= '0;
                        r_state <= r_last ? S_P_OUTER : S_IDLE;
                    end else if (w_idx_valid) begin
                        r_state <= S_FIND_CMP;
                    end else begin
                        if (!r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_idx[IDX_W-1:0];
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FIND_CMP: begin
                    if (w_flags.eq) begin
                        r_hit   <= r_idx[IDX_W-1:0];
                        r_low   <= w_rd_low;
                        r_high  <= w_rd_high;
                        r_state <= S_MIN;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_FIND;
                    end
                end
                S_MIN: begin
                    if (w_flags.lt) begin
                        r_low <= r_local;
                    end
                    r_state <= S_MAX;
                end
                S_MAX: begin
                    if (w_flags.lt) begin
                        r_high <= r_end;
                    end
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_idx   <= '0;
                    r_total <= '0;
                    r_state <= r_last ? S_P_OUTER : S_IDLE;
                end
                S_P_OUTER: begin
                    if (w_idx_end) begin
                        r_packed    <= 1'b1;
                        r_res_pack  <= 1'b1;
                        r_res_found <= 1'b0;
                        r_res_off   <= '0;
                        r_state     <= S_OUT;
                    end else if (w_idx_valid) begin
                        r_state <= S_P_LOADI;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_P_LOADI: begin
                    r_ikey  <= w_rd_key;
                    r_span  <= w_alu_res[HIGH_W-1:0];
                    r_state <= S_P_TOT;
                end
                S_P_TOT: begin
                    r_total <= w_alu_res[OUT_W-1:0];
                    r_acc   <= '0;
                    r_jdx   <= '0;
                    r_state <= S_P_INNER;
                end
                S_P_INNER: begin
                    if (w_jdx_end) begin
                        // segment base for entry r_idx written this cycle
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_P_OUTER;
                    end else if (w_jdx_valid) begin
                        r_state <= S_P_LT;
                    end else begin
                        r_jdx <= r_jdx + 1'b1;
                    end
                end
                S_P_LT: begin
                    if (w_flags.lt) begin
                        r_state <= S_P_SUBJ;
                    end else begin
                        r_jdx   <= r_jdx + 1'b1;
                        r_state <= S_P_INNER;
                    end
                end
                S_P_SUBJ: begin
                    r_span  <= w_alu_res[HIGH_W-1:0];
                    r_state <= S_P_ACC;
                end
                S_P_ACC: begin
                    r_acc   <= w_alu_res[OUT_W-1:0];
                    r_jdx   <= r_jdx + 1'b1;
                    r_state <= S_P_INNER;
                end
                S_L_FIND: begin
                    if (w_idx_end) begin
                        r_state <= S_OUT;
                    end else if (w_idx_valid) begin
                        r_state <= S_L_CMP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_L_CMP: begin
                    if (w_flags.eq) begin
                        r_state <= S_L_GE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_L_FIND;
                    end
                end
                S_L_GE: begin
                    r_state <= w_flags.lt ? S_OUT : S_L_OFF;
                end
                S_L_OFF: begin
                    r_off   <= w_alu_res[HIGH_W-1:0];
                    r_state <= S_L_SPAN;
                end
                S_L_SPAN: begin
                    r_span  <= w_alu_res[HIGH_W-1:0];
                    r_state <= S_L_IN;
                end
                S_L_IN: begin
                    r_state <= w_flags.lt ? S_L_ADD : S_OUT;
                end
                S_L_ADD: begin
                    r_res_found <= 1'b1;
                    r_res_off   <= w_alu_res[OUT_W-1:0];
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register valid: a new load wins over the drain of the old transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload, loaded when the transaction enters the output register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_found <= r_res_found;
            r_out_off   <= r_res_off;
            r_out_total <= r_packed ? r_total : '0;
            r_out_ovf   <= r_overflow;
            r_out_pack  <= r_res_pack;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_ovf, r_out_total, r_out_off, r_out_found};
    assign o_m_tuser  = r_out_pack;

endmodule

// File: bench/testbench.sv
// Self-checking bench for the channel span packer and address translator.
`timescale 1ns / 1ps
module testbench;

    localparam int   REGIONS       = 16;
    localparam int   LOCAL_W       = 36;
    localparam int   CHAN_W        = csp_pkg::ADDR_W - LOCAL_W;
    localparam logic KIND_CHUNK    = 1'b0;
    localparam logic KIND_LOOKUP   = 1'b1;
    localparam int   CYCLE_LIMIT   = 4_000_000;
    localparam int   HOLD_CYCLES   = 2000;
    localparam int   SETTLE_CYCLES = 800;
    localparam int   MAX_REPORTS   = 10;

    // Same bit order as {o_m_tuser, o_m_tdata[83:0]}
    typedef struct packed {
        logic                      pack;
        logic                      overflow;
        logic [csp_pkg::OUT_W-1:0] total;
        logic [csp_pkg::OUT_W-1:0] offset;
        logic                      found;
    } t_span_result;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [csp_pkg::S_TDATA_W-1:0] i_s_tdata  = '0;
    logic                          i_s_tuser  = 1'b0;
    logic                          i_s_tlast  = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [csp_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic                          o_m_tuser;

    channel_span_pack_and_translate u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Span table mirror
    logic                      span_valid [REGIONS];
    logic [7:0]                span_dev   [REGIONS];
    logic [CHAN_W-1:0]         span_chan  [REGIONS];
    logic [LOCAL_W-1:0]        span_low   [REGIONS];
    logic [LOCAL_W:0]          span_high  [REGIONS];
    logic [csp_pkg::OUT_W-1:0] span_seg   [REGIONS];
    logic [csp_pkg::OUT_W-1:0] span_total;
    logic                      span_packed;
    logic                      span_overflow;

    t_span_result expected_results [$];

    int send_idle_pct = 6;
    int recv_idle_pct = 46;
    bit hold_go       = 1'b0;
    int hold_count    = 0;
    int cycle_count   = 0;
    int error_count   = 0;
    int items_sent    = 0;
    int chunk_count   = 0;
    int lookup_count  = 0;
    int results_seen  = 0;
    int packs_seen    = 0;
    int hits_seen     = 0;
    int overflow_seen = 0;

    function automatic logic [LOCAL_W-1:0] rand_local();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[LOCAL_W-1:0];
    endfunction

    function automatic void span_clear();
        for (int i = 0; i < REGIONS; i++) span_valid[i] = 1'b0;
        span_total    = '0;
        span_packed   = 1'b0;
        span_overflow = 1'b0;
    endfunction

    function automatic int span_find(input logic [7:0] dev, input logic [CHAN_W-1:0] chan);
        for (int i = 0; i < REGIONS; i++)
            if (span_valid[i] && span_dev[i] == dev && span_chan[i] == chan) return i;
        return -1;
    endfunction

    // Ordering is device first, then channel
    function automatic bit key_below(input int a, input int b);
        if (span_dev[a] != span_dev[b]) return span_dev[a] < span_dev[b];
        return span_chan[a] < span_chan[b];
    endfunction

    function automatic void span_pack();
        logic [csp_pkg::OUT_W-1:0] sum;
        logic [csp_pkg::OUT_W-1:0] base;
        sum = '0;
        for (int i = 0; i < REGIONS; i++) begin
            if (span_valid[i]) begin
                base = '0;
                for (int j = 0; j < REGIONS; j++)
                    if (span_valid[j] && key_below(j, i))
                        base = base + (span_high[j] - span_low[j]);
                span_seg[i] = base;
                sum = sum + (span_high[i] - span_low[i]);
            end
        end
        span_total  = sum;
        span_packed = 1'b1;
    endfunction

    // Returns 1 when the transaction produces a result
    function automatic bit span_predict(input logic kind, input logic [7:0] dev,
                                        input logic [63:0] addr, input logic [31:0] size,
                                        input logic last, output t_span_result res);
        logic [LOCAL_W-1:0] loc_off;
        logic [CHAN_W-1:0]  chan;
        logic [LOCAL_W:0]   end_addr;
        logic [LOCAL_W:0]   off;
        int                 idx;
        int                 slot;
        loc_off = addr[LOCAL_W-1:0];
        chan    = addr[csp_pkg::ADDR_W-1:LOCAL_W];
        res     = '0;
        if (kind == KIND_CHUNK) begin
            if (span_packed) span_clear();
            if (size != 0) begin
                idx      = span_find(dev, chan);
                end_addr = loc_off + size;
                if (idx >= 0) begin
                    if (loc_off < span_low[idx]) span_low[idx] = loc_off;
                    if (end_addr > span_high[idx]) span_high[idx] = end_addr;
                end else begin
                    slot = -1;
                    for (int i = 0; i < REGIONS; i++)
                        if (!span_valid[i] && slot < 0) slot = i;
                    if (slot >= 0) begin
                        span_valid[slot] = 1'b1;
                        span_dev[slot]   = dev;
                        span_chan[slot]  = chan;
                        span_low[slot]   = loc_off;
                        span_high[slot]  = end_addr;
                    end else begin
                        span_overflow = 1'b1;
                    end
                end
            end
            if (!last) return 1'b0;
            span_pack();
            res.total    = span_total;
            res.overflow = span_overflow;
            res.pack     = 1'b1;
            return 1'b1;
        end
        res.total    = span_packed ? span_total : '0;
        res.overflow = span_overflow;
        if (span_packed) begin
            idx = span_find(dev, chan);
            if (idx >= 0 && loc_off >= span_low[idx]) begin
                off = loc_off - span_low[idx];
                if (off < span_high[idx] - span_low[idx]) begin
                    res.found  = 1'b1;
                    res.offset = span_seg[idx] + off;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void report_mismatch(input string what, input t_span_result want,
                                            input t_span_result got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("MISMATCH (%0s) at cycle %0d", what, cycle_count);
            $display("  expected found=%0b offset=%h total=%h ovf=%0b pack=%0b",
                     want.found, want.offset, want.total, want.overflow, want.pack);
            $display("  actual   found=%0b offset=%h total=%h ovf=%0b pack=%0b",
                     got.found, got.offset, got.total, got.overflow, got.pack);
        end
    endfunction

    // Receiver: random tready, one long hold-off on request, result checking
    always @(posedge i_clk) begin
        t_span_result got;
        t_span_result want;
        if (hold_go && hold_count < HOLD_CYCLES) begin
            hold_count++;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser, o_m_tdata[2*csp_pkg::OUT_W+1:0]};
            results_seen++;
            if (got.pack) packs_seen++;
            if (got.found) hits_seen++;
            if (got.overflow) overflow_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch("no transaction expected", '0, got);
            end else begin
                want = expected_results.pop_front();
                if (got.found !== want.found || got.offset !== want.offset ||
                    got.total !== want.total || got.overflow !== want.overflow ||
                    got.pack !== want.pack)
                    report_mismatch("field", want, got);
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] dev, input logic [63:0] addr,
                             input logic [31:0] size, input logic last);
        t_span_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {size, addr, dev};
        i_s_tuser  <= kind;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (span_predict(kind, dev, addr, size, last, res))
            expected_results = {expected_results, res};
        items_sent++;
        if (kind == KIND_CHUNK) chunk_count++;
        else lookup_count++;
    endtask

    task automatic wait_results_done();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Lookup aimed mostly at live spans: interior, both edges, just outside
    task automatic send_lookup();
        int                 live [$];
        int                 pick;
        logic [LOCAL_W-1:0] loc;
        logic [63:0]        span_len;
        logic [7:0]         dev;
        logic [63:0]        addr;
        for (int i = 0; i < REGIONS; i++)
            if (span_valid[i]) live = {live, i};
        if (!span_packed || live.size() == 0 || $urandom_range(9) == 0) begin
            dev  = 8'($urandom);
            addr = {$urandom, $urandom};
        end else begin
            pick     = live[$urandom_range(live.size() - 1)];
            dev      = span_dev[pick];
            span_len = 64'(span_high[pick] - span_low[pick]);
            case ($urandom_range(9))
                0:       loc = span_low[pick];
                1:       loc = LOCAL_W'(span_high[pick] - 1'b1);
                2:       loc = LOCAL_W'(span_high[pick]);
                3:       loc = span_low[pick] - 1'b1;
                4:       loc = rand_local();
                default: loc = span_low[pick] + LOCAL_W'({$urandom, $urandom} % span_len);
            endcase
            addr = {span_chan[pick], loc};
            if ($urandom_range(19) == 0) addr[csp_pkg::ADDR_W-1:LOCAL_W] = CHAN_W'($urandom);
        end
        send_item(KIND_LOOKUP, dev, addr, $urandom, 1'($urandom_range(1)));
    endtask

    // One collection run: chunks over a key pool, usually closed by tlast, then lookups
    task automatic run_frame(input int keys_lo, input int keys_hi,
                             input int chunks_lo, input int chunks_hi);
        logic [7:0]         pool_dev  [20];
        logic [CHAN_W-1:0]  pool_chan [20];
        logic [LOCAL_W-1:0] pool_base [20];
        int                 n_keys;
        int                 n_chunks;
        int                 pick;
        logic [LOCAL_W-1:0] loc;
        logic [31:0]        sz;
        logic               closes;
        n_keys   = $urandom_range(keys_hi, keys_lo);
        n_chunks = $urandom_range(chunks_hi, chunks_lo);
        for (int k = 0; k < n_keys; k++) begin
            pool_dev[k]  = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(3));
            pool_chan[k] = $urandom_range(1) ? CHAN_W'($urandom) : CHAN_W'(k);
            pool_base[k] = rand_local();
        end
        closes = ($urandom_range(9) != 0);
        for (int c = 0; c < n_chunks; c++) begin
            if ($urandom_range(99) < 8) send_lookup();
            pick = (c < n_keys) ? c : $urandom_range(n_keys - 1);
            loc  = ($urandom_range(9) < 7) ? pool_base[pick] + LOCAL_W'($urandom_range(8191))
                                           : rand_local();
            case ($urandom_range(19))
                0, 1:    sz = '0;
                2, 3, 4: sz = $urandom;
                5, 6, 7: sz = $urandom_range(1 << 20, 1);
                default: sz = $urandom_range(4096, 1);
            endcase
            send_item(KIND_CHUNK, pool_dev[pick], {pool_chan[pick], loc}, sz,
                      closes && (c == n_chunks - 1));
        end
        repeat ($urandom_range(12, 3)) send_lookup();
    endtask

    task automatic test_lookup_before_pack();
        send_item(KIND_LOOKUP, 8'hFF, '1, 32'hFFFF_FFFF, 1'b1);
        send_item(KIND_LOOKUP, 8'h00, '0, 32'h0, 1'b0);
        wait_results_done();
    endtask

    task automatic test_directed_spans();
        send_item(KIND_CHUNK, 8'h00, 64'h0, 32'd1, 1'b0);
        send_item(KIND_CHUNK, 8'h00, 64'd100, 32'd0, 1'b0);
        send_item(KIND_CHUNK, 8'hFF, '1, 32'hFFFF_FFFF, 1'b0);
        send_item(KIND_CHUNK, 8'hFF, 64'hFFFF_FFF0_0000_0010, 32'd8, 1'b0);
        send_item(KIND_CHUNK, 8'h00, 64'h0000_0010_0000_0000, 32'h1000, 1'b1);
        send_item(KIND_LOOKUP, 8'h00, 64'h0, 32'd0, 1'b0);
        send_item(KIND_LOOKUP, 8'h00, 64'h0000_0010_0000_0FFF, 32'd0, 1'b0);
        send_item(KIND_LOOKUP, 8'h00, 64'h0000_0010_0000_1000, 32'd0, 1'b0);
        send_item(KIND_LOOKUP, 8'hFF, 64'hFFFF_FFF0_0000_000F, 32'd0, 1'b0);
        send_item(KIND_LOOKUP, 8'hFF, '1, 32'd0, 1'b0);
        send_item(KIND_LOOKUP, 8'h01, 64'h0, 32'd0, 1'b0);
        send_item(KIND_LOOKUP, 8'h00, 64'h1, 32'd0, 1'b0);
        wait_results_done();
    endtask

    task automatic test_repack_and_empty();
        // first chunk after a pack clears the table
        send_item(KIND_CHUNK, 8'h07, 64'h5, 32'd3, 1'b0);
        send_item(KIND_LOOKUP, 8'h00, 64'h0, 32'd0, 1'b0);
        send_item(KIND_CHUNK, 8'h07, 64'h9, 32'd2, 1'b1);
        send_item(KIND_LOOKUP, 8'h07, 64'hA, 32'd0, 1'b0);
        // zero-size tlast chunk: clear, then pack nothing
        send_item(KIND_CHUNK, 8'h07, 64'h20, 32'd0, 1'b1);
        send_item(KIND_LOOKUP, 8'h07, 64'h5, 32'd0, 1'b0);
        wait_results_done();
    endtask

    task automatic test_table_overflow();
        repeat (3) run_frame(17, 20, 20, 36);
        wait_results_done();
    endtask

    task automatic test_backpressure();
        hold_go = 1'b1;
        repeat (3) run_frame(2, 6, 4, 10);
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target        = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(14) == 0) run_frame(14, 20, 14, 30);
            else run_frame(1, 16, 1, 20);
        end
        wait_results_done();
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Run stopped at the cycle limit with %0d results outstanding",
                 expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        span_clear();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_lookup_before_pack();
        test_directed_spans();
        test_repack_and_empty();
        test_table_overflow();
        test_backpressure();
        test_random_traffic(6, 46, 350);
        test_random_traffic(46, 6, 350);
        test_random_traffic(0, 0, 350);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            error_count += expected_results.size();
        end
        $display("Sent %0d transactions (%0d chunks, %0d lookups), checked %0d results",
                 items_sent, chunk_count, lookup_count, results_seen);
        $display("Seen %0d pack results, %0d lookup hits, %0d with overflow set; %0d errors",
                 packs_seen, hits_seen, overflow_seen, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
